### hw/rtl/rrts_pkg.sv
// Shared constants, codes and control types of the round-robin tick task scheduler.
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

    localparam int TASK_COUNT_DEF = 4;

    localparam int REQ_W      = 3;
    localparam int TASK_IDX_W = 4;
    localparam int DATA_W     = 32;
    localparam int STATE_W    = 2;
    localparam int SLICE_W    = 8;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

    typedef logic [REQ_W-1:0]   req_type_t;
    typedef logic [STATE_W-1:0] tstate_t;
    typedef logic [1:0]         rd_sel_t;

    // request codes
    localparam req_type_t REQ_TICK   = 3'd0;
    localparam req_type_t REQ_SWITCH = 3'd1;
    localparam req_type_t REQ_SLEEP  = 3'd2;
    localparam req_type_t REQ_SET    = 3'd3;
    localparam req_type_t REQ_READ   = 3'd4;

    // task states
    localparam tstate_t ST_READY    = 2'd0;
    localparam tstate_t ST_RUNNING  = 2'd1;
    localparam tstate_t ST_SLEEPING = 2'd2;
    localparam tstate_t ST_BLOCKED  = 2'd3;

    // table read address select
    localparam rd_sel_t RD_IDX = 2'd0;
    localparam rd_sel_t RD_CUR = 2'd1;
    localparam rd_sel_t RD_NXT = 2'd2;

    typedef struct packed {
        logic    load_req;
        logic    do_tick;
        logic    sw_init;
        logic    scan_step;
        logic    sw_commit;
        logic    do_sleep;
        logic    do_set;
        logic    load_out;
        rd_sel_t rd_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        req_type_t req_type;
        logic      scan_hit;
        logic      scan_end;
    } dp_sts_t;

endpackage

`default_nettype wire

### hw/rtl/rrts_if.sv
// Request and response channel interfaces of the scheduler.
`timescale 1ns / 1ps
`default_nettype none

interface rrts_req_if
    import rrts_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [REQ_W-1:0]      req_type;
    logic [TASK_IDX_W-1:0] task_index;
    logic [DATA_W-1:0]     sleep_ticks;
    logic [STATE_W-1:0]    new_state;

    modport source (output valid, req_type, task_index, sleep_ticks, new_state, input ready);
    modport sink   (input valid, req_type, task_index, sleep_ticks, new_state, output ready);
endinterface

interface rrts_rsp_if
    import rrts_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  switch_due;
    logic [TASK_IDX_W-1:0] running_task;
    logic [DATA_W-1:0]     tick_count;
    logic [DATA_W-1:0]     switch_count;
    logic [STATE_W-1:0]    addressed_state;
    logic [DATA_W-1:0]     addressed_run_ticks;

    modport source (output valid, switch_due, running_task, tick_count, switch_count,
                    addressed_state, addressed_run_ticks, input ready);
    modport sink   (input valid, switch_due, running_task, tick_count, switch_count,
                    addressed_state, addressed_run_ticks, output ready);
endinterface

`default_nettype wire

### hw/rtl/rrts_datapath.sv
// Scheduler datapath: task tables, counters, scan pointer and output word register.
`timescale 1ns / 1ps
`default_nettype none

module rrts_datapath
    import rrts_pkg::*;
#(
    parameter int TASK_COUNT = TASK_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_sts_t               sts,
    input  logic                  cfg_we,
    input  logic [SLICE_W-1:0]    cfg_data,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [TASK_IDX_W-1:0] task_index,
    input  logic [DATA_W-1:0]     sleep_ticks,
    input  logic [STATE_W-1:0]    new_state,
    output logic                  switch_due,
    output logic [TASK_IDX_W-1:0] running_task,
    output logic [DATA_W-1:0]     tick_count,
    output logic [DATA_W-1:0]     switch_count,
    output logic [STATE_W-1:0]    addressed_state,
    output logic [DATA_W-1:0]     addressed_run_ticks
);

    localparam int IDX_W  = $clog2(TASK_COUNT);
    localparam int SEEN_W = $clog2(TASK_COUNT + 1);
    localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(TASK_COUNT - 1);
    localparam logic [SEEN_W-1:0]     SEEN_END = SEEN_W'(TASK_COUNT);
    localparam logic [TASK_IDX_W:0]   TC_LIM   = (TASK_IDX_W + 1)'(TASK_COUNT);

    // latched request word
    req_type_t             req_type_reg;
    logic [TASK_IDX_W-1:0] idx_reg;
    logic [DATA_W-1:0]     sleep_reg;
    tstate_t               nst_reg;

    tstate_t            state_reg [TASK_COUNT];
    tstate_t            state_next[TASK_COUNT];
    logic [DATA_W-1:0]  wake_reg  [TASK_COUNT];
    logic [DATA_W-1:0]  wake_next [TASK_COUNT];
    logic [DATA_W-1:0]  run_reg   [TASK_COUNT];
    logic [DATA_W-1:0]  run_next  [TASK_COUNT];

    logic [DATA_W-1:0]  tick_reg, tick_next;
    logic [DATA_W-1:0]  swc_reg, swc_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [SLICE_W-1:0] slice_cnt_reg, slice_cnt_next;
    logic [SLICE_W-1:0] slice_ticks_reg, slice_ticks_next;
    logic               due_reg, due_next;

    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [SEEN_W-1:0]  seen_reg, seen_next;
    logic [IDX_W-1:0]   chosen_reg, chosen_next;

    logic                  o_due_reg;
    logic [TASK_IDX_W-1:0] o_task_reg;
    logic [DATA_W-1:0]     o_tick_reg;
    logic [DATA_W-1:0]     o_swc_reg;
    tstate_t               o_state_reg;
    logic [DATA_W-1:0]     o_run_reg;

    logic               idx_valid;
    logic [IDX_W-1:0]   idx_t;
    logic [IDX_W-1:0]   nxt;
    logic [SEEN_W-1:0]  seen_inc;
    logic [IDX_W-1:0]   rd_addr;
    tstate_t            state_rd;
    logic [DATA_W-1:0]  run_rd;
    logic [DATA_W-1:0]  tick_inc;
    logic [SLICE_W-1:0] cnt_dec;

    assign idx_valid = ({1'b0, idx_reg} < TC_LIM);
    assign idx_t     = idx_reg[IDX_W-1:0];
    assign nxt       = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
    assign seen_inc  = seen_reg + 1'b1;
    assign tick_inc  = tick_reg + 1'b1;
    assign cnt_dec   = slice_cnt_reg - 1'b1;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_CUR:  rd_addr = cur_reg;
            RD_NXT:  rd_addr = nxt;
            default: rd_addr = idx_t;
        endcase
    end

    assign state_rd = state_reg[rd_addr];
    assign run_rd   = run_reg[rd_addr];

    // status comes from registers only, so it never depends on the command
    assign sts.req_type = req_type_reg;
    assign sts.scan_hit = (state_reg[nxt] == ST_READY);
    assign sts.scan_end = (seen_inc >= SEEN_END);

    always_comb
    begin
        state_next       = state_reg;
        wake_next        = wake_reg;
        run_next         = run_reg;
        tick_next        = tick_reg;
        swc_next         = swc_reg;
        cur_next         = cur_reg;
        slice_cnt_next   = slice_cnt_reg;
        slice_ticks_next = slice_ticks_reg;
        due_next         = due_reg;
        ptr_next         = ptr_reg;
        seen_next        = seen_reg;
        chosen_next      = chosen_reg;

        if (cfg_we)
        begin
            slice_ticks_next = cfg_data;
        end

        if (cmd.load_req)
        begin
            due_next = 1'b0;
        end

        if (cmd.do_tick)
        begin
            tick_next = tick_inc;
            // read port addresses the current task here
            if (state_rd == ST_RUNNING)
            begin
                run_next[cur_reg] = run_rd + 1'b1;
            end
            for (int k = 0; k < TASK_COUNT; k++)
            begin
                if (state_reg[k] == ST_SLEEPING && tick_inc >= wake_reg[k])
                begin
                    state_next[k] = ST_READY;
                end
            end
            if (cnt_dec == '0)
            begin
                slice_cnt_next = slice_ticks_reg;
                due_next       = 1'b1;
            end
            else
            begin
                slice_cnt_next = cnt_dec;
            end
        end

        if (cmd.sw_init)
        begin
            swc_next  = swc_reg + 1'b1;
            ptr_next  = cur_reg;
            seen_next = '0;
        end

        if (cmd.scan_step)
        begin
            seen_next = seen_inc;
            ptr_next  = nxt;
            if (sts.scan_end)
            begin
                chosen_next = '0;      // nobody ready: fall back to task 0
            end
            else if (sts.scan_hit)
            begin
                chosen_next = nxt;
            end
        end

        if (cmd.sw_commit)
        begin
            if (chosen_reg != cur_reg && state_rd == ST_RUNNING)
            begin
                state_next[cur_reg] = ST_READY;
            end
            state_next[chosen_reg] = ST_RUNNING;
            cur_next               = chosen_reg;
        end

        if (cmd.do_sleep && idx_valid)
        begin
            wake_next[idx_t]  = tick_reg + sleep_reg;
            state_next[idx_t] = ST_SLEEPING;
        end

        if (cmd.do_set && idx_valid)
        begin
            state_next[idx_t] = nst_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TASK_COUNT; k++)
            begin
                state_reg[k] <= ST_READY;
                wake_reg[k]  <= '0;
                run_reg[k]   <= '0;
            end
            tick_reg        <= '0;
            swc_reg         <= '0;
            cur_reg         <= '0;
            slice_cnt_reg   <= SLICE_RESET;
            slice_ticks_reg <= SLICE_RESET;
            due_reg         <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            wake_reg        <= wake_next;
            run_reg         <= run_next;
            tick_reg        <= tick_next;
            swc_reg         <= swc_next;
            cur_reg         <= cur_next;
            slice_cnt_reg   <= slice_cnt_next;
            slice_ticks_reg <= slice_ticks_next;
            due_reg         <= due_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        seen_reg   <= seen_next;
        chosen_reg <= chosen_next;
        if (cmd.load_req)
        begin
            req_type_reg <= req_type;
            idx_reg      <= task_index;
            sleep_reg    <= sleep_ticks;
            nst_reg      <= new_state;
        end
        if (cmd.load_out)
        begin
            o_due_reg   <= due_reg;
            o_task_reg  <= TASK_IDX_W'(cur_reg);
            o_tick_reg  <= tick_reg;
            o_swc_reg   <= swc_reg;
            o_state_reg <= idx_valid ? state_rd : ST_READY;
            o_run_reg   <= idx_valid ? run_rd : '0;
        end
    end

    assign switch_due          = o_due_reg;
    assign running_task        = o_task_reg;
    assign tick_count          = o_tick_reg;
    assign switch_count        = o_swc_reg;
    assign addressed_state     = o_state_reg;
    assign addressed_run_ticks = o_run_reg;

    a_due_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        due_reg |-> req_type_reg == REQ_TICK)
        else $error("slice end flagged for a request other than a tick");

    a_commit_running: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sw_commit |=> state_reg[cur_reg] == ST_RUNNING)
        else $error("switched-to task not running after commit");

    a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= LAST_IDX)
        else $error("current task out of range");

endmodule

`default_nettype wire

### hw/rtl/rrts_ctrl.sv
// Scheduler controller: sequences each request word through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  dp_sts_t   sts,
    output ctrl_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_IDX;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (sts.req_type)
                    REQ_TICK:
                    begin
                        cmd.do_tick = 1'b1;
                        cmd.rd_sel  = RD_CUR;
                    end
                    REQ_SWITCH:
                    begin
                        cmd.sw_init = 1'b1;
                        state_next  = S_SCAN;
                    end
                    REQ_SLEEP: cmd.do_sleep = 1'b1;
                    REQ_SET:   cmd.do_set   = 1'b1;
                    default:   ;    // read only and unused codes
                endcase
            end
            S_SCAN:
            begin
                cmd.rd_sel    = RD_NXT;
                cmd.scan_step = 1'b1;
                if (sts.scan_end || sts.scan_hit)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.rd_sel    = RD_CUR;
                cmd.sw_commit = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("output word raised outside the done state");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> state_reg == S_DONE)
        else $error("finished word left done state while output register full");

    a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_req |=> state_reg == S_EXEC)
        else $error("accepted request word not executed next cycle");

endmodule

`default_nettype wire

### hw/rtl/round_robin_tick_task_scheduler_unit.sv
// Top level of the round-robin tick task scheduler.
//
//  channel | dir | handshake        | word
//  req     | in  | valid / ready    | req_type, task_index, sleep_ticks, new_state
//  rsp     | out | valid / ready    | switch_due, running_task, tick_count,
//          |     |                  | switch_count, addressed_state, addressed_run_ticks
//  cfg     | in  | cfg_we           | cfg_data = slice_ticks
//
// Tick, sleep, set-state and read words pass through the exec and done states
// before the next accept. A switch passes through exec, k = 1..TASK_COUNT steps of
// the round-robin scan, then commit and done, one task state read per cycle.
// Reset is asynchronous and clears all tables and counters at once.
// A finished word waits in the output register; the next request word is accepted
// while it waits, and stays in the done state only if the register is full and unread.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_tick_task_scheduler_unit
    import rrts_pkg::*;
#(
    parameter int TASK_COUNT = TASK_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SLICE_W-1:0] cfg_data,
    rrts_req_if.sink           req,
    rrts_rsp_if.source         rsp
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    rrts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rrts_datapath #(
        .TASK_COUNT (TASK_COUNT)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .cfg_we              (cfg_we),
        .cfg_data            (cfg_data),
        .req_type            (req.req_type),
        .task_index          (req.task_index),
        .sleep_ticks         (req.sleep_ticks),
        .new_state           (req.new_state),
        .switch_due          (rsp.switch_due),
        .running_task        (rsp.running_task),
        .tick_count          (rsp.tick_count),
        .switch_count        (rsp.switch_count),
        .addressed_state     (rsp.addressed_state),
        .addressed_run_ticks (rsp.addressed_run_ticks)
    );

endmodule

`default_nettype wire

### bench/schedule_checker.sv
// Scheduler checker: predicts every response word and compares it with the block output.
`timescale 1ns / 1ps

module schedule_checker
    import rrts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SLICE_W-1:0] cfg_data,
    rrts_req_if                req,
    rrts_rsp_if                rsp,
    output int                 errors,
    output int                 pending
);

    localparam int TASKS = TASK_COUNT_DEF;

    typedef struct packed {
        logic                  switch_due;
        logic [TASK_IDX_W-1:0] running_task;
        logic [DATA_W-1:0]     tick_count;
        logic [DATA_W-1:0]     switch_count;
        tstate_t               addressed_state;
        logic [DATA_W-1:0]     addressed_run_ticks;
    } sched_word_t;

    // scheduler state as predicted
    tstate_t               task_st   [TASKS];
    logic [DATA_W-1:0]     wake_at   [TASKS];
    logic [DATA_W-1:0]     run_cnt   [TASKS];
    logic [DATA_W-1:0]     ticks;
    logic [DATA_W-1:0]     switches;
    logic [SLICE_W-1:0]    slice_left;
    logic [SLICE_W-1:0]    slice_len;
    logic [TASK_IDX_W-1:0] cur_task;

    sched_word_t expected_words [$];
    sched_word_t got_word;
    sched_word_t want_word;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [DATA_W-1:0] got_v,
                                 input logic [DATA_W-1:0] want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got_v, want_v));
    endtask

    function automatic sched_word_t schedule_request(input req_type_t kind,
                                                     input logic [TASK_IDX_W-1:0] idx,
                                                     input logic [DATA_W-1:0] nap,
                                                     input tstate_t st);
        sched_word_t w;
        logic        hit;
        logic        found;
        int          pick;
        int          cand;
        w     = '0;
        hit   = (idx < TASKS);
        found = 1'b0;
        pick  = 0;
        case (kind)
            REQ_TICK:
            begin
                ticks = ticks + 1'b1;
                if (task_st[cur_task] == ST_RUNNING)
                    run_cnt[cur_task] = run_cnt[cur_task] + 1'b1;
                for (int k = 0; k < TASKS; k++)
                begin
                    if (task_st[k] == ST_SLEEPING && ticks >= wake_at[k])
                        task_st[k] = ST_READY;
                end
                slice_left = slice_left - 1'b1;
                if (slice_left == '0)
                begin
                    slice_left   = slice_len;
                    w.switch_due = 1'b1;
                end
            end
            REQ_SWITCH:
            begin
                switches = switches + 1'b1;
                // scan the other tasks in order; none ready falls back to task 0
                for (int s = 1; s < TASKS; s++)
                begin
                    cand = (int'(cur_task) + s) % TASKS;
                    if (!found && task_st[cand] == ST_READY)
                    begin
                        pick  = cand;
                        found = 1'b1;
                    end
                end
                if (pick != cur_task && task_st[cur_task] == ST_RUNNING)
                    task_st[cur_task] = ST_READY;
                task_st[pick] = ST_RUNNING;
                cur_task      = TASK_IDX_W'(pick);
            end
            REQ_SLEEP:
            begin
                if (hit)
                begin
                    wake_at[idx] = ticks + nap;
                    task_st[idx] = ST_SLEEPING;
                end
            end
            REQ_SET:
            begin
                if (hit)
                    task_st[idx] = st;
            end
            default:
            begin
            end
        endcase
        w.running_task = cur_task;
        w.tick_count   = ticks;
        w.switch_count = switches;
        if (hit)
        begin
            w.addressed_state     = task_st[idx];
            w.addressed_run_ticks = run_cnt[idx];
        end
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TASKS; k++)
            begin
                task_st[k] = ST_READY;
                wake_at[k] = '0;
                run_cnt[k] = '0;
            end
            ticks      = '0;
            switches   = '0;
            slice_left = SLICE_RESET;
            slice_len  = SLICE_RESET;
            cur_task   = '0;
            expected_words.delete();
            pending    = 0;
        end
        else
        begin
            // responses first: a word can never leave at the edge it was accepted
            if (rsp.valid && rsp.ready)
            begin
                got_word.switch_due          = rsp.switch_due;
                got_word.running_task        = rsp.running_task;
                got_word.tick_count          = rsp.tick_count;
                got_word.switch_count        = rsp.switch_count;
                got_word.addressed_state     = rsp.addressed_state;
                got_word.addressed_run_ticks = rsp.addressed_run_ticks;
                if (expected_words.size() == 0)
                    report_mismatch("response word with nothing outstanding");
                else
                begin
                    want_word = expected_words.pop_front();
                    compare_field("switch_due", got_word.switch_due, want_word.switch_due);
                    compare_field("running_task", got_word.running_task,
                                  want_word.running_task);
                    compare_field("tick_count", got_word.tick_count, want_word.tick_count);
                    compare_field("switch_count", got_word.switch_count,
                                  want_word.switch_count);
                    compare_field("addressed_state", got_word.addressed_state,
                                  want_word.addressed_state);
                    compare_field("addressed_run_ticks", got_word.addressed_run_ticks,
                                  want_word.addressed_run_ticks);
                end
            end
            if (req.valid && req.ready)
                expected_words.push_back(schedule_request(req.req_type, req.task_index,
                                                          req.sleep_ticks, req.new_state));
            if (cfg_we)
                slice_len = cfg_data;
            pending = expected_words.size();
        end
    end

endmodule

### bench/testbench.sv
// Testbench top: clock, reset, request stimulus, response stalls, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;

    import rrts_pkg::*;

    localparam int TASKS        = TASK_COUNT_DEF;
    localparam int RANDOM_WORDS = 1150;
    localparam int PHASES       = 6;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;

    // request codes the block treats as plain reads
    localparam req_type_t REQ_RSVD_FIRST = 3'd5;
    localparam req_type_t REQ_RSVD_LAST  = 3'd7;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we;
    logic [SLICE_W-1:0] cfg_data;

    int errors;
    int pending;
    int burst_left  = 1;
    int idle_cycles = 0;

    rrts_req_if req_ch ();
    rrts_rsp_if rsp_ch ();

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    round_robin_tick_task_scheduler_unit #(
        .TASK_COUNT(TASKS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    schedule_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .errors   (errors),
        .pending  (pending)
    );

    // one request word; valid stays high inside a burst, a gap follows each burst
    task automatic send_word(input req_type_t kind, input logic [TASK_IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] nap, input tstate_t st);
        int gap;
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.task_index  <= idx;
        req_ch.sleep_ticks <= nap;
        req_ch.new_state   <= st;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            req_ch.valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_slice(input logic [SLICE_W-1:0] value);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic send_random_word();
        int                    pick;
        int                    r;
        req_type_t             kind;
        logic [TASK_IDX_W-1:0] idx;
        logic [DATA_W-1:0]     nap;
        tstate_t               st;
        pick = $urandom_range(0, 99);
        if (pick < 42)
            kind = REQ_TICK;
        else if (pick < 58)
            kind = REQ_SWITCH;
        else if (pick < 74)
            kind = REQ_SLEEP;
        else if (pick < 88)
            kind = REQ_SET;
        else if (pick < 95)
            kind = REQ_READ;
        else
            kind = req_type_t'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST));
        if ($urandom_range(0, 99) < 85)
            idx = TASK_IDX_W'($urandom_range(0, TASKS - 1));
        else
            idx = TASK_IDX_W'($urandom_range(0, (1 << TASK_IDX_W) - 1));
        // mostly short sleeps so tasks wake again; some full-range ones wrap
        r = $urandom_range(0, 99);
        if (r < 60)
            nap = $urandom_range(0, 12);
        else if (r < 85)
            nap = $urandom_range(0, 400);
        else
            nap = $urandom;
        st = tstate_t'($urandom_range(0, (1 << STATE_W) - 1));
        send_word(kind, idx, nap, st);
    endtask

    initial
    begin
        int rsp_mode;
        int rsp_cyc;
        rsp_mode = 0;
        rsp_cyc  = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_cyc++;
            if (rsp_cyc % 48 == 0)
                rsp_mode = $urandom_range(0, 3);
            case (rsp_mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       rsp_ch.ready <= ((rsp_cyc % 7) >= 3);
                default: rsp_ch.ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        logic [SLICE_W-1:0] slice_plan [PHASES];
        slice_plan    = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd10, 8'd1};
        slice_plan[PHASES - 1] = $urandom_range(1, 255);
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_READ;
        req_ch.task_index  <= '0;
        req_ch.sleep_ticks <= '0;
        req_ch.new_state   <= ST_READY;
        cfg_we             <= 1'b0;
        cfg_data           <= SLICE_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset slice length
        send_word(REQ_READ,   4'd0,  32'h0000_0000, ST_READY);
        send_word(REQ_TICK,   4'd0,  32'h0000_0000, ST_READY);
        send_word(REQ_SWITCH, 4'd1,  32'h0000_0000, ST_READY);
        send_word(REQ_TICK,   4'd1,  32'h0000_0000, ST_READY);
        send_word(REQ_SLEEP,  4'd2,  32'h0000_0000, ST_READY);
        send_word(REQ_SLEEP,  4'd3,  32'hFFFF_FFFF, ST_BLOCKED);
        send_word(REQ_TICK,   4'd3,  32'h0000_0000, ST_READY);
        send_word(REQ_SET,    4'd0,  32'h0000_0000, ST_BLOCKED);
        send_word(REQ_SET,    4'd2,  32'h0000_0000, ST_SLEEPING);
        send_word(REQ_SET,    4'd3,  32'h0000_0000, ST_RUNNING);
        // out-of-range task index
        send_word(REQ_SLEEP,  4'd15, 32'h5A5A_A5A5, ST_READY);
        send_word(REQ_SET,    4'd4,  32'h0000_0000, ST_BLOCKED);
        send_word(REQ_READ,   4'd15, 32'hFFFF_FFFF, ST_BLOCKED);
        send_word(REQ_RSVD_FIRST,      4'd1, 32'h0000_0000, ST_READY);
        send_word(REQ_RSVD_FIRST + 1'b1, 4'd1, 32'h0000_0000, ST_READY);
        send_word(REQ_RSVD_LAST,       4'd1, 32'h0000_0000, ST_READY);
        // nothing ready: switch falls back to task 0, then switches onto itself
        send_word(REQ_SET,    4'd1,  32'h0000_0000, ST_BLOCKED);
        send_word(REQ_SET,    4'd2,  32'h0000_0000, ST_BLOCKED);
        send_word(REQ_SET,    4'd3,  32'h0000_0000, ST_BLOCKED);
        send_word(REQ_SET,    4'd0,  32'h0000_0000, ST_BLOCKED);
        send_word(REQ_SWITCH, 4'd0,  32'h0000_0000, ST_READY);
        send_word(REQ_SWITCH, 4'd0,  32'h0000_0000, ST_READY);
        send_word(REQ_TICK,   4'd0,  32'h0000_0000, ST_READY);
        send_word(REQ_READ,   4'd0,  32'h0000_0000, ST_READY);

        for (int p = 0; p < PHASES; p++)
        begin
            write_slice(slice_plan[p]);
            repeat (RANDOM_WORDS / PHASES) send_random_word();
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### round_robin_tick_task_scheduler_unit.f
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_if.sv
hw/rtl/rrts_datapath.sv
hw/rtl/rrts_ctrl.sv
hw/rtl/round_robin_tick_task_scheduler_unit.sv
bench/schedule_checker.sv
bench/testbench.sv
